// ===== design/mfe_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the message frame encoder.
package mfe_pkg;

   // Input beat: eight message bytes and the polling round.
   typedef struct packed {
      logic [63:0] payload;
      logic [7:0]  round_number;
   } req_type;

   // Output beat: one bus byte and its end-of-sequence mark.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // Classified message waiting between the front and back parts.
   typedef struct packed {
      logic [63:0] payload;
      logic        rnd_hi;
      logic        rnd_lo;
      logic        empty;
   } job_type;

   localparam logic [7:0] CMD_EMPTY = 8'h70;
   localparam logic [7:0] CMD_SEND  = 8'h78;
   localparam logic [7:0] SIZE_BYTE = 8'h01;
   localparam logic [7:0] CRC_POLY  = 8'h8C;

   // Byte positions within a frame.
   localparam logic [3:0] POS_CMD     = 4'd0;
   localparam logic [3:0] POS_SIZE    = 4'd1;
   localparam logic [3:0] POS_RND_HI  = 4'd2;
   localparam logic [3:0] POS_RND_LO  = 4'd3;
   localparam logic [3:0] POS_PAY_0   = 4'd4;
   localparam logic [3:0] POS_CRC     = 4'd12;

   // Reflected CRC-8, one byte, LSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] crc;
      logic [7:0] dat;
      logic       mix;
      crc = crc_in;
      dat = data;
      for (int k = 0; k < 8; k++) begin
         mix = crc[0] ^ dat[0];
         crc = crc >> 1;
         if (mix) begin
            crc = crc ^ CRC_POLY;
         end
         dat = dat >> 1;
      end
      return crc;
   endfunction

endpackage

// ===== design/mfe_front.sv =====
// Front part: accepts messages, flags empty ones and queues them for the serializer.
module mfe_front import mfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job_data,
   input  logic    job_pop
);

   job_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   job_type    job_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_pop && job_valid;
   assign job_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      job_new.payload = req_data.payload;
      job_new.rnd_hi  = req_data.round_number[4];
      job_new.rnd_lo  = req_data.round_number[0];
      job_new.empty   = (req_data.payload == 64'd0);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

// ===== design/mfe_back.sv =====
// Back part: walks a queued message out byte by byte with a running CRC-8.
module mfe_back import mfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job_data,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       advance;
   logic [7:0] cur_byte;
   logic       cur_last;
   logic [3:0] pay_pos;
   logic [2:0] pay_idx;

   assign advance   = job_valid && (!rsp_valid_ff || !rsp_stall);
   assign pay_pos   = pos_ff - POS_PAY_0;
   assign pay_idx   = pay_pos[2:0];
   assign cur_last  = job_data.empty || (pos_ff == POS_CRC);
   assign job_pop   = advance && cur_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (pos_ff)
         POS_CMD:    cur_byte = job_data.empty ? CMD_EMPTY : CMD_SEND;
         POS_SIZE:   cur_byte = SIZE_BYTE;
         POS_RND_HI: cur_byte = {7'd0, job_data.rnd_hi};
         POS_RND_LO: cur_byte = {3'd0, job_data.rnd_lo, 4'd0};
         POS_CRC:    cur_byte = crc_ff;
         default:    cur_byte = job_data.payload[pay_idx*8 +: 8];
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = cur_byte;
         rsp_data_in.last_byte = cur_last;
         if (cur_last) begin
            pos_in = POS_CMD;
            crc_in = 8'd0;
         end else begin
            pos_in = pos_ff + 4'd1;
            crc_in = crc8_byte(crc_ff, cur_byte);
         end
      end else if (!rsp_stall) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_CMD;
         crc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/message_frame_encoder_crc8.sv =====
// Message frame encoder: turns one 8-byte message into its bus byte sequence.
//
// Request channel (req_valid/req_stall/req_data) takes one message per beat:
// the 64-bit payload and the round number. A message whose payload is all
// zero gives a single result byte 0x70. Any other message gives a 13-byte
// frame: 0x78, 0x01, round bit 4, round bit 0 shifted to bit 4, the eight
// payload bytes lowest first, then a reflected CRC-8 (poly 0x8C, init 0)
// over the twelve bytes before it. The final byte carries last_byte = 1.
// An accepted message is written into the queue, and its first byte is then
// registered in the back part's output register. Throughput: one result byte
// per cycle while rsp_stall is low, set by the byte serializer in the back part.
// A two-entry queue sits between the input and the serializer, so new
// messages are accepted while a frame is still going out.
// When rsp_stall is high the current byte holds; the serializer pauses and
// req_stall rises once the queue is full. Reset empties the queue and drops
// any byte in flight.
module message_frame_encoder_crc8 import mfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    job_valid;
   job_type job_data;
   logic    job_pop;

   mfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   mfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/mfe_checker.sv =====
// Port-level checks for the message frame encoder, bound to the top level.
module mfe_checker import mfe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic       req_beat;
   logic       rsp_beat;
   logic       rsp_end;
   logic [1:0] pending_ff, pending_in;
   logic [3:0] bpos_ff, bpos_in;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign rsp_end  = rsp_beat && rsp_data.last_byte;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_beat} - {1'b0, rsp_end};
      bpos_in    = bpos_ff;
      if (rsp_end) begin
         bpos_in = 4'd0;
      end else if (rsp_beat) begin
         bpos_in = bpos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         bpos_ff    <= 4'd0;
      end else begin
         pending_ff <= pending_in;
         bpos_ff    <= bpos_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result beat without an accepted message");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_byte |-> bpos_ff < 4'd12)
      else $error("frame longer than thirteen bytes");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bpos_ff == 4'd0 |->
         (rsp_data.out_byte == CMD_EMPTY && rsp_data.last_byte) ||
         (rsp_data.out_byte == CMD_SEND && !rsp_data.last_byte))
      else $error("sequence does not open with a command byte");

endmodule

bind message_frame_encoder_crc8 mfe_checker u_mfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/message_frame_encoder_crc8_tb.sv =====
// Self-checking testbench for the message frame encoder with CRC-8 trailer.
module message_frame_encoder_crc8_tb;
   import mfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 20;
   localparam int FRAME_BYTES  = 13;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Bus bytes still owed by the encoder, oldest first.
   rsp_type bus_bytes_due[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int error_count    = 0;
   int messages_sent  = 0;
   int empty_sent     = 0;
   int bytes_checked  = 0;
   int quiet_cycles   = 0;

   message_frame_encoder_crc8 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Reflected CRC-8, one byte, data LSB first.
   function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = {1'b0, acc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   // Queue the bus bytes one message must produce.
   function automatic void queue_bus_bytes(input req_type msg);
      logic [7:0] frame[FRAME_BYTES];
      logic [7:0] crc;
      rsp_type    beat;
      crc = 8'h00;
      if (msg.payload == 64'd0) begin
         beat.out_byte  = CMD_EMPTY;
         beat.last_byte = 1'b1;
         bus_bytes_due.push_back(beat);
         return;
      end
      frame[0] = CMD_SEND;
      frame[1] = SIZE_BYTE;
      frame[2] = {7'd0, msg.round_number[4]};
      frame[3] = {3'd0, msg.round_number[0], 4'd0};
      for (int i = 0; i < 8; i++)
         frame[4 + i] = msg.payload[8 * i +: 8];
      for (int i = 0; i < FRAME_BYTES - 1; i++)
         crc = crc8_fold(crc, frame[i]);
      frame[FRAME_BYTES - 1] = crc;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         beat.out_byte  = frame[i];
         beat.last_byte = (i == FRAME_BYTES - 1);
         bus_bytes_due.push_back(beat);
      end
   endfunction

   // Predict on every accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         queue_bus_bytes(req_data);
         messages_sent++;
         if (req_data.payload == 64'd0)
            empty_sent++;
      end
   end

   // Check every accepted result beat against the oldest owed byte.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (bus_bytes_due.size() == 0) begin
            $error("unexpected beat: out_byte %h last_byte %b",
                   rsp_data.out_byte, rsp_data.last_byte);
            error_count++;
         end else begin
            want = bus_bytes_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_data.last_byte);
               error_count++;
            end
         end
      end
   end

   // Random receiver back-pressure.
   always @(posedge clock)
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one message and hold it until accepted.
   task automatic send_message(input logic [63:0] payload, input logic [7:0] round_number);
      req_type msg;
      msg.payload      = payload;
      msg.round_number = round_number;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= msg;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and wait for every owed byte.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      // let the last accepted beat reach the predictor first
      @(posedge clock);
      while (bus_bytes_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] random_payload();
      logic [63:0] pay;
      int          pick;
      pick = $urandom_range(99);
      pay  = {$urandom(), $urandom()};
      if (pick < 12)
         pay = 64'd0;
      else if (pick < 25) begin
         pay = 64'd0;
         pay[8 * $urandom_range(7) +: 8] = 8'($urandom_range(255, 1));
      end else if (pick < 32)
         pay = ~64'd0 ^ (64'd1 << $urandom_range(63));
      else if (pick < 40)
         pay = 64'd1 << $urandom_range(63);
      return pay;
   endfunction

   task automatic test_directed();
      send_message(64'd0, 8'h00);                    // empty message
      send_message(64'd0, 8'hFF);                    // empty, round bits ignored
      send_message(~64'd0, 8'hFF);
      send_message(64'd1, 8'h00);
      send_message(64'h8000_0000_0000_0000, 8'h11);
      send_message(64'h0000_0000_0000_00FF, 8'h10);
      send_message(64'hFF00_0000_0000_0000, 8'h01);
      send_message(64'h0123_4567_89AB_CDEF, 8'hEE);  // only unused round bits set
      send_message(64'h0123_4567_89AB_CDEF, 8'h00);
      send_message(64'hFEDC_BA98_7654_3210, 8'hEF);
      send_message(64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
      send_message(64'h5555_5555_5555_5555, 8'hAA);
      send_message(64'd0, 8'h11);
      send_message(64'hA5A5_A5A5_A5A5_A5A5, 8'h11);  // repeat: state must not leak
      send_message(64'hA5A5_A5A5_A5A5_A5A5, 8'h11);
      send_message(64'd0, 8'h00);
      send_message(~64'd0, 8'h00);
      hold_until_drained();
   endtask

   task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++)
         send_message(random_payload(), 8'($urandom_range(255)));
      hold_until_drained();
   endtask

   task automatic test_pause_until_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 50;
      for (int n = 0; n < 10; n++) begin
         send_message(random_payload(), 8'($urandom_range(255)));
         if (n % 3 == 2)
            hold_until_drained();
      end
      hold_until_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(60, 0, 0);
      test_random_phase(50, 74, 0);
      test_random_phase(50, 0, 74);
      test_random_phase(60, 38, 38);
      test_pause_until_drained();

      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bus_bytes_due.size() != 0) begin
         $error("%0d bus bytes never arrived", bus_bytes_due.size());
         error_count++;
      end

      $display("Encoded %0d messages (%0d empty) and checked %0d bus bytes,",
               messages_sent, empty_sent, bytes_checked);
      $display("with sender gaps and receiver stalls mixed over five phases.");
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mfe_pkg.sv
design/mfe_front.sv
design/mfe_back.sv
design/message_frame_encoder_crc8.sv
design/mfe_checker.sv
test/message_frame_encoder_crc8_tb.sv
